[sv/mtf_pkg.sv]
// Shared types and constants of the move-to-front list core.
package mtf_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 16;

  localparam int IN_ID_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int POS_OUT_W = 4;
  localparam int CNT_OUT_W = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_ACCESS = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_MOVED     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

  // Broadcast controls from the sequencer to every list cell.
  typedef struct packed {
    logic launch;  // start a search: token into cell 0, clear passed marks
    logic step;    // token moves one cell toward the tail
    logic stop;    // search over: drop the token
    logic move;    // shift marked cells back by one, match cell included
    logic wr_en;   // insert write into the selected cell
  } cell_ctl_t;

endpackage

[sv/mtf_cell.sv]
// One list cell: a slot, the search token and the mark of cells the token has passed.
module mtf_cell #(
  parameter int ID_WIDTH = mtf_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mtf_pkg::cell_ctl_t  ctl,
  input  logic                wr_sel,
  input  logic [ID_WIDTH-1:0] wr_data,
  input  logic [ID_WIDTH-1:0] key,
  input  logic [ID_WIDTH-1:0] left_slot,
  input  logic                left_tok,
  output logic [ID_WIDTH-1:0] slot,
  output logic                tok,
  output logic                hit
);
  import mtf_pkg::*;

  logic [ID_WIDTH-1:0] slot_r, slot_nxt;
  logic                tok_r, tok_nxt;
  logic                passed_r, passed_nxt;

  always_comb begin
    tok_nxt    = tok_r;
    passed_nxt = passed_r;
    slot_nxt   = slot_r;
    if (ctl.launch || ctl.step) begin
      tok_nxt = left_tok;
    end else if (ctl.stop) begin
      tok_nxt = 1'b0;
    end
    if (ctl.launch) begin
      passed_nxt = 1'b0;
    end else if (ctl.step) begin
      passed_nxt = passed_r | tok_r;
    end
    // Cells in front of the match and the match itself take their neighbor's value.
    if (ctl.move && (passed_r || tok_r)) begin
      slot_nxt = left_slot;
    end else if (ctl.wr_en && wr_sel) begin
      slot_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      tok_r    <= tok_nxt;
      passed_r <= passed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;
  assign tok  = tok_r;
  assign hit  = tok_r && (slot_r == key);

endmodule

[sv/move_to_front_list_core.sv]
// Top level of the move-to-front list core: sequencer, cell chain and result register.
// Insert, full and empty results are registered and appear in the cycle after acceptance.
// An access sends the search token into cell 0; the token walks one cell per cycle, and
// the result is registered when it reaches the match or the last occupied cell.
// One insert per cycle while results drain; an access blocks input until its search ends.
// Reset (rst_n low, synchronous) empties the list; slot contents are not cleared.
module move_to_front_list_core #(
  parameter int DEPTH    = mtf_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = mtf_pkg::ID_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item: tuser[0] = kind (0 insert, 1 access).
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] entry_id
  input  logic [0:0]  in_tuser,   // [0] kind
  // Result item.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [6:3] found_position,
                                  // [11:7] entry_count, [15:12] zero
);
  import mtf_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Control state.
  state_t                state_r, state_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [ID_WIDTH-1:0]   key_r, key_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [POS_OUT_W-1:0]  res_pos_r, res_pos_nxt;
  logic [CNT_OUT_W-1:0]  res_cnt_r, res_cnt_nxt;

  cell_ctl_t             ctl;
  logic                  accept;
  logic                  load_out;
  logic                  hit_any;
  logic [ID_WIDTH-1:0]   in_key;
  logic [ID_WIDTH+IN_ID_W-1:0] in_key_ext;
  logic [OCC_W+CNT_OUT_W-1:0]  cnt_ext;
  logic [POS_W+POS_OUT_W-1:0]  pos_ext;

  logic [ID_WIDTH-1:0]   slot_vec [DEPTH];
  logic [DEPTH-1:0]      tok_vec;
  logic [DEPTH-1:0]      hit_vec;

  // Only the low ID_WIDTH bits of the identifier take part; wider IDs zero-extend.
  assign in_key_ext = {{ID_WIDTH{1'b0}}, in_tdata};
  assign in_key     = in_key_ext[ID_WIDTH-1:0];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign hit_any   = |hit_vec;

  // Sequencer: inserts and trivial refusals finish at once; an access walks the chain.
  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    ctl            = '0;
    load_out       = 1'b0;
    res_status_nxt = res_status_r;
    res_pos_nxt    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt  = in_key;
          if (kind_t'(in_tuser[0]) == KIND_INSERT) begin
            load_out = 1'b1;
            if (occ_r == OCC_W'(DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              ctl.wr_en      = 1'b1;
              occ_nxt        = occ_r + OCC_W'(1);
              res_status_nxt = ST_INSERTED;
            end
          end else if (occ_r == '0) begin
            load_out       = 1'b1;
            res_status_nxt = ST_EMPTY;
          end else begin
            ctl.launch = 1'b1;
            pos_nxt    = '0;
            state_nxt  = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit_any) begin
          // The match cell and every cell the token passed shift back; key enters at 0.
          ctl.move       = 1'b1;
          ctl.stop       = 1'b1;
          load_out       = 1'b1;
          res_status_nxt = ST_MOVED;
          res_pos_nxt    = pos_ext[POS_OUT_W-1:0];
          state_nxt      = S_IDLE;
        end else if ((OCC_W+1)'(pos_r) + (OCC_W+1)'(1) == (OCC_W+1)'(occ_r)) begin
          ctl.stop       = 1'b1;
          load_out       = 1'b1;
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          ctl.step = 1'b1;
          pos_nxt  = pos_r + POS_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign pos_ext     = {{POS_OUT_W{1'b0}}, pos_r};
  assign cnt_ext     = {{CNT_OUT_W{1'b0}}, occ_nxt};
  assign res_cnt_nxt = load_out ? cnt_ext[CNT_OUT_W-1:0] : res_cnt_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (load_out) begin
      res_status_r <= res_status_nxt;
      res_pos_r    <= res_pos_nxt;
    end
    res_cnt_r <= res_cnt_nxt;
  end

  // The chain of cells; cell 0 sees the search key as its left neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] left_slot;
    logic                left_tok;
    if (i == 0) begin : g_head
      assign left_slot = key_r;
      assign left_tok  = ctl.launch;
    end else begin : g_body
      assign left_slot = slot_vec[i-1];
      assign left_tok  = tok_vec[i-1];
    end
    mtf_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .wr_sel    (occ_r == OCC_W'(i)),
      .wr_data   (in_key),
      .key       (key_r),
      .left_slot (left_slot),
      .left_tok  (left_tok),
      .slot      (slot_vec[i]),
      .tok       (tok_vec[i]),
      .hit       (hit_vec[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_cnt_r, res_pos_r, res_status_r};

`ifndef ASSERT_OFF
  // At most one search token lives in the chain.
  a_tok_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one search token in the chain");

  // While searching, the token sits exactly at the tracked position.
  a_tok_at_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (tok_vec[pos_r] && $onehot(tok_vec)))
    else $error("search token not at the tracked position");

  // The token never probes a cell beyond the occupied part of the list.
  a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> ((OCC_W+1)'(pos_r) < (OCC_W+1)'(occ_r)))
    else $error("search token beyond the list tail");

  // Occupancy stays in range and a move never changes it.
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy exceeds depth");

  a_move_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |=> $stable(occ_r))
    else $error("occupancy changed during an access");
`endif

endmodule
